// ----- rtl/olmrs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olmrs_pkg: shared definitions for the ordered list block
// List capacity, field widths, command codes and the store port structs.
// ----------------------------------------------------------------------------
package olmrs_pkg;

	localparam int CAPACITY = 256;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CMD_W    = 3;
	localparam int FIELD_W  = 9;

	localparam logic [FIELD_W:0] CAP_X = (FIELD_W + 1)'(CAPACITY);

	localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_TOP    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_BOTTOM = 3'd2;
	localparam logic [CMD_W-1:0] CMD_MOVE   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ASK    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd5;

	typedef struct packed {
		logic [ADDR_W-1:0]  iap_raddr;
		logic               iap_we;
		logic [ADDR_W-1:0]  iap_waddr;
		logic [FIELD_W-1:0] iap_wdata;
		logic [ADDR_W-1:0]  poi_raddr;
		logic               poi_we;
		logic [ADDR_W-1:0]  poi_waddr;
		logic [FIELD_W-1:0] poi_wdata;
	} store_req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] iap_rdata;
		logic [FIELD_W-1:0] poi_rdata;
	} store_rsp_t;

endpackage

// ----- rtl/olmrs_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olmrs_store: item-at-place and place-of-item memories
// One write and one registered read per memory and cycle. Place-of-item
// entries carry valid bits so that an absent item reads as zero.
// ----------------------------------------------------------------------------
module olmrs_store (
	input  logic                    clk,
	input  logic                    arst_n,
	input  olmrs_pkg::store_req_t   req,
	output olmrs_pkg::store_rsp_t   rsp
);

	logic [olmrs_pkg::FIELD_W-1:0]  iap_mem [olmrs_pkg::CAPACITY];
	logic [olmrs_pkg::FIELD_W-1:0]  poi_mem [olmrs_pkg::CAPACITY];
	logic [olmrs_pkg::CAPACITY-1:0] poi_v_q;
	logic [olmrs_pkg::FIELD_W-1:0]  iap_rd_q;
	logic [olmrs_pkg::FIELD_W-1:0]  poi_rd_q;
	logic                           poi_vr_q;

	always_ff @(posedge clk) begin
		if (req.iap_we) begin
			iap_mem[req.iap_waddr] <= req.iap_wdata;
		end
		iap_rd_q <= iap_mem[req.iap_raddr];
		if (req.poi_we) begin
			poi_mem[req.poi_waddr] <= req.poi_wdata;
		end
		poi_rd_q <= poi_mem[req.poi_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poi_v_q  <= '0;
			poi_vr_q <= 1'b0;
		end else begin
			if (req.poi_we) begin
				poi_v_q[req.poi_waddr] <= 1'b1;
			end
			poi_vr_q <= poi_v_q[req.poi_raddr];
		end
	end

	assign rsp.iap_rdata = iap_rd_q;
	assign rsp.poi_rdata = poi_vr_q ? poi_rd_q : '0;

endmodule

// ----- rtl/ordered_list_move_rank_select.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_move_rank_select: ordered list with move, rank and select
// Keeps up to CAPACITY distinct items in order; load, top, bottom, move,
// ask (rank) and query (select), with an error result for bad requests.
// ----------------------------------------------------------------------------
// One command at a time. The place-of-item lookup is issued as a command is
// taken, and the decision follows on the registered read; load then finishes,
// ask and errors go on to the output register, and query first reads the item
// at the place. Top, bottom and move walk the list through one shared step unit,
// a memory read and then a write-back for each place that closes up, and last
// store the moved item. The single read port of each memory sets this pace.
// Valid bits clear at reset, so the block is ready right away. A finished
// result waits in the output register while the next command is taken.
module ordered_list_move_rank_select (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [olmrs_pkg::CMD_W-1:0]         cmd,
	input  logic [olmrs_pkg::FIELD_W-1:0]       target,
	input  logic signed [olmrs_pkg::FIELD_W-1:0] offset,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [olmrs_pkg::FIELD_W-1:0]       answer,
	output logic                                status
);

	localparam int F = olmrs_pkg::FIELD_W;
	localparam int A = olmrs_pkg::ADDR_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOOK = 3'd1;
	localparam logic [2:0] ST_SRD  = 3'd2;
	localparam logic [2:0] ST_SWR  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;
	localparam logic [2:0] ST_QRD  = 3'd5;
	localparam logic [2:0] ST_EMIT = 3'd6;

	logic [2:0]                  state_q;
	logic [olmrs_pkg::CMD_W-1:0] cmd_q;
	logic [F-1:0]                target_q;
	logic signed [F-1:0]         offset_q;
	logic [F-1:0]                count_q;
	logic [F-1:0]                p_q;
	logic [F-1:0]                dst_q;
	logic                        up_q;
	logic [F-1:0]                res_answer_q;
	logic                        res_status_q;
	logic                        out_valid_q;
	logic [F-1:0]                answer_q;
	logic                        status_q;

	olmrs_pkg::store_req_t req;
	olmrs_pkg::store_rsp_t rsp;

	logic [F-1:0]          k;
	logic                  target_ok;
	logic                  cmd_err;
	logic                  load_ok;
	logic                  query_ok;
	logic signed [F+1:0]   move_t;
	logic                  move_ok;
	logic                  reloc_ok;
	logic [F-1:0]          reloc_dst;
	logic [F-1:0]          p_next;
	logic                  out_take;
	logic                  out_free;

	olmrs_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign k         = rsp.poi_rdata;
	assign target_ok = (target_q != '0) && ({1'b0, target_q} <= olmrs_pkg::CAP_X);
	assign cmd_err   = (cmd_q > olmrs_pkg::CMD_QUERY)
			|| ((cmd_q <= olmrs_pkg::CMD_ASK)
			&& (!target_ok || (cmd_q != olmrs_pkg::CMD_LOAD && k == '0)));
	assign load_ok   = (k == '0) && ({1'b0, count_q} < olmrs_pkg::CAP_X);
	assign query_ok  = (target_q != '0) && (target_q <= count_q);
	assign move_t    = $signed({2'b00, k}) + $signed({{2{offset_q[F-1]}}, offset_q});
	assign move_ok   = (move_t >= 1) && (move_t <= $signed({2'b00, count_q}));
	assign reloc_ok  = !cmd_err
			&& ((cmd_q inside {olmrs_pkg::CMD_TOP, olmrs_pkg::CMD_BOTTOM})
			|| (cmd_q == olmrs_pkg::CMD_MOVE && move_ok));

	always_comb begin
		case (cmd_q)
			olmrs_pkg::CMD_TOP:    reloc_dst = F'(1);
			olmrs_pkg::CMD_BOTTOM: reloc_dst = count_q;
			default:               reloc_dst = move_t[F-1:0];
		endcase
	end

	assign p_next   = up_q ? p_q + F'(1) : p_q - F'(1);
	assign out_take = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		req           = '0;
		req.poi_raddr = A'(target - F'(1));
		case (state_q)
			ST_LOOK: begin
				req.iap_raddr = A'(target_q - F'(1));
				if (!cmd_err && cmd_q == olmrs_pkg::CMD_LOAD && load_ok) begin
					req.iap_we    = 1'b1;
					req.iap_waddr = count_q[A-1:0];
					req.iap_wdata = target_q;
					req.poi_we    = 1'b1;
					req.poi_waddr = A'(target_q - F'(1));
					req.poi_wdata = count_q + F'(1);
				end
			end
			ST_SRD: begin
				req.iap_raddr = up_q ? A'(p_q) : A'(p_q - F'(2));
			end
			ST_SWR: begin
				req.iap_we    = 1'b1;
				req.iap_waddr = A'(p_q - F'(1));
				req.iap_wdata = rsp.iap_rdata;
				req.poi_we    = 1'b1;
				req.poi_waddr = A'(rsp.iap_rdata - F'(1));
				req.poi_wdata = p_q;
			end
			ST_FIN: begin
				req.iap_we    = 1'b1;
				req.iap_waddr = A'(dst_q - F'(1));
				req.iap_wdata = target_q;
				req.poi_we    = 1'b1;
				req.poi_waddr = A'(target_q - F'(1));
				req.poi_wdata = dst_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cmd_q        <= '0;
			target_q     <= '0;
			offset_q     <= '0;
			count_q      <= '0;
			p_q          <= '0;
			dst_q        <= '0;
			up_q         <= 1'b0;
			res_answer_q <= '0;
			res_status_q <= 1'b0;
			out_valid_q  <= 1'b0;
			answer_q     <= '0;
			status_q     <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q    <= cmd;
						target_q <= target;
						offset_q <= offset;
						state_q  <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (!cmd_err && cmd_q == olmrs_pkg::CMD_LOAD && load_ok) begin
						count_q <= count_q + F'(1);
						state_q <= ST_IDLE;
					end else if (reloc_ok) begin
						dst_q   <= reloc_dst;
						p_q     <= k;
						up_q    <= reloc_dst > k;
						state_q <= (reloc_dst == k) ? ST_FIN : ST_SRD;
					end else if (!cmd_err && cmd_q == olmrs_pkg::CMD_ASK) begin
						res_answer_q <= k - F'(1);
						res_status_q <= 1'b0;
						state_q      <= ST_EMIT;
					end else if (!cmd_err && cmd_q == olmrs_pkg::CMD_QUERY && query_ok) begin
						state_q <= ST_QRD;
					end else begin
						res_answer_q <= '0;
						res_status_q <= 1'b1;
						state_q      <= ST_EMIT;
					end
				end
				ST_SRD: begin
					state_q <= ST_SWR;
				end
				ST_SWR: begin
					p_q     <= p_next;
					state_q <= (p_next == dst_q) ? ST_FIN : ST_SRD;
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				ST_QRD: begin
					res_answer_q <= rsp.iap_rdata;
					res_status_q <= 1'b0;
					state_q      <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						answer_q <= res_answer_q;
						status_q <= res_status_q;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign answer    = answer_q;
	assign status    = status_q;

endmodule

// ----- test/tb_ordered_list_move_rank_select.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_move_rank_select: self-checking bench for the ordered list
// Drives load, top, bottom, move, ask and query commands, plus malformed ones,
// through the valid/stall channels with random gaps and a long output hold-off.
// A scoreboard keeps its own copy of the list, predicts each reply and checks
// every returned transfer against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_ordered_list_move_rank_select;
	import olmrs_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int DRAIN_CYCLES = 3 + 2 * CAPACITY + 64;
	localparam int RANDOM_ITEMS = 1625;
	localparam int HOLD_CYCLES  = 300;
	localparam int LIMIT_CYCLES = 6_000_000;

	typedef struct packed {
		logic [FIELD_W-1:0] answer;
		logic               status;
	} reply_t;

	class rank_scoreboard;
		int     item_at [1:CAPACITY];
		int     place_of [1:CAPACITY];
		int     count;
		reply_t expected_replies[$];
		int     accepted;
		int     checked;
		int     error_replies;
		int     mismatches;
		int     per_cmd [8];

		function new();
			count = 0;
			accepted = 0;
			checked = 0;
			error_replies = 0;
			mismatches = 0;
			foreach (place_of[i]) place_of[i] = 0;
			foreach (item_at[i]) item_at[i] = 0;
			foreach (per_cmd[i]) per_cmd[i] = 0;
		endfunction

		function void close_up(int src, int dst);
			int moved;
			moved = item_at[src];
			if (dst > src) begin
				for (int i = src; i < dst; i++) begin
					item_at[i] = item_at[i + 1];
					place_of[item_at[i]] = i;
				end
			end else begin
				for (int i = src; i > dst; i--) begin
					item_at[i] = item_at[i - 1];
					place_of[item_at[i]] = i;
				end
			end
			item_at[dst] = moved;
			place_of[moved] = dst;
		endfunction

		function void note_command(logic [CMD_W-1:0] c, logic [FIELD_W-1:0] t,
				logic signed [FIELD_W-1:0] o);
			int     k;
			int     dst;
			bit     err;
			bit     emit;
			reply_t r;
			k = 0;
			err = 1'b0;
			emit = 1'b0;
			r = '0;
			accepted++;
			per_cmd[c]++;
			if (c <= CMD_ASK) begin
				if (t < 1 || t > CAPACITY) begin
					err = 1'b1;
				end else begin
					k = place_of[t];
					if (c != CMD_LOAD && k == 0) err = 1'b1;
				end
			end
			if (!err) begin
				case (c)
					CMD_LOAD: begin
						if (k != 0 || count >= CAPACITY) begin
							err = 1'b1;
						end else begin
							count++;
							item_at[count] = t;
							place_of[t] = count;
						end
					end
					CMD_TOP:    close_up(k, 1);
					CMD_BOTTOM: close_up(k, count);
					CMD_MOVE: begin
						dst = k + int'(o);
						if (dst < 1 || dst > count) err = 1'b1;
						else close_up(k, dst);
					end
					CMD_ASK: begin
						r.answer = FIELD_W'(k - 1);
						emit = 1'b1;
					end
					CMD_QUERY: begin
						if (t < 1 || t > count) begin
							err = 1'b1;
						end else begin
							r.answer = FIELD_W'(item_at[t]);
							emit = 1'b1;
						end
					end
					default: err = 1'b1;
				endcase
			end
			if (err) begin
				r.answer = '0;
				r.status = 1'b1;
				error_replies++;
				expected_replies.push_back(r);
			end else if (emit) begin
				r.status = 1'b0;
				expected_replies.push_back(r);
			end
		endfunction

		task report(string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			mismatches++;
		endtask

		task check_result(logic [FIELD_W-1:0] a, logic s);
			reply_t want;
			checked++;
			if (expected_replies.size() == 0) begin
				report($sformatf("reply answer=%0d status=%0d with none pending", a, s));
			end else begin
				want = expected_replies.pop_front();
				if (a !== want.answer)
					report($sformatf("answer %0d, predicted %0d", a, want.answer));
				if (s !== want.status)
					report($sformatf("status %0d, predicted %0d", s, want.status));
			end
		endtask
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [CMD_W-1:0]           cmd;
	logic [FIELD_W-1:0]         target;
	logic signed [FIELD_W-1:0]  offset;
	logic                       out_valid;
	logic                       out_stall;
	logic [FIELD_W-1:0]         answer;
	logic                       status;

	rank_scoreboard sb;
	bit             calm;

	ordered_list_move_rank_select DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.target    (target),
		.offset    (offset),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.answer    (answer),
		.status    (status)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(CLK_PERIOD * LIMIT_CYCLES);
		$display("TB_ERROR");
		$finish;
	end

	task send_command(logic [CMD_W-1:0] c, int t, int o);
		while (!calm && $urandom_range(0, 99) < 30) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		target   <= t[FIELD_W-1:0];
		offset   <= o[FIELD_W-1:0];
		do @(posedge clk); while (in_stall);
		sb.note_command(c, t[FIELD_W-1:0], o[FIELD_W-1:0]);
	endtask

	task random_command(int goal, output logic [CMD_W-1:0] c, output int t,
			output int o);
		int  r;
		int  sel;
		bit  want_load;
		r = $urandom_range(0, 99);
		o = int'($urandom_range(0, 511)) - 256;
		if (r < 8) begin
			c = CMD_W'($urandom_range(0, 7));
			t = $urandom_range(0, 511);
			return;
		end
		want_load = sb.count == 0 || (r < 45 && sb.count < goal) || r < 11;
		if (want_load) begin
			c = CMD_LOAD;
			if (sb.count < goal && $urandom_range(0, 9) != 0) begin
				t = $urandom_range(1, CAPACITY);
				while (sb.place_of[t] != 0) t = (t % CAPACITY) + 1;
			end else if (sb.count > 0) begin
				t = sb.item_at[$urandom_range(1, sb.count)];
			end else begin
				t = $urandom_range(0, 511);
			end
			return;
		end
		sel = $urandom_range(0, 99);
		if (sel < 15)      c = CMD_TOP;
		else if (sel < 30) c = CMD_BOTTOM;
		else if (sel < 60) c = CMD_MOVE;
		else if (sel < 80) c = CMD_ASK;
		else               c = CMD_QUERY;
		if (c == CMD_QUERY) begin
			if ($urandom_range(0, 9) == 0) t = $urandom_range(0, 511);
			else t = $urandom_range(1, sb.count);
			return;
		end
		if ($urandom_range(0, 19) == 0) t = $urandom_range(0, 511);
		else t = sb.item_at[$urandom_range(1, sb.count)];
		if (c == CMD_MOVE) begin
			sel = $urandom_range(0, 9);
			if (sel < 5)
				o = int'($urandom_range(0, 12)) - 6;
			else if (sel < 8 && t >= 1 && t <= CAPACITY && sb.place_of[t] != 0)
				o = int'($urandom_range(1, sb.count)) - sb.place_of[t];
		end
	endtask

	initial begin
		int               peak;
		logic [CMD_W-1:0] c;
		int               t;
		int               o;
		sb = new();
		calm = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_LOAD;
		target = '0;
		offset = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_command(CMD_ASK, 5, 0);
		send_command(CMD_TOP, 2, 0);
		send_command(CMD_LOAD, 0, 0);
		send_command(CMD_LOAD, 257, 0);
		send_command(CMD_LOAD, 511, 0);
		send_command(CMD_LOAD, 256, 0);
		send_command(CMD_LOAD, 1, 0);
		send_command(CMD_LOAD, 170, 0);
		send_command(CMD_LOAD, 85, 0);
		send_command(CMD_LOAD, 1, 0);
		send_command(CMD_TOP, 85, 0);
		send_command(CMD_BOTTOM, 256, 0);
		send_command(CMD_MOVE, 1, 2);
		send_command(CMD_MOVE, 170, -1);
		send_command(CMD_MOVE, 256, 0);
		send_command(CMD_MOVE, 85, 3);
		send_command(CMD_MOVE, 85, -255);
		send_command(CMD_MOVE, 1, -256);
		send_command(CMD_MOVE, 1, 255);
		send_command(CMD_ASK, 1, 0);
		send_command(CMD_QUERY, 0, 0);
		send_command(CMD_QUERY, 4, 0);
		send_command(CMD_QUERY, 5, 0);
		send_command(3'd6, 0, 0);
		send_command(3'd7, 511, -1);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = n >= 400 && n < 600;
			random_command(n < 900 ? 40 : CAPACITY, c, t, o);
			send_command(c, t, o);
		end
		calm = 1'b0;
		in_valid <= 1'b0;
		peak = sb.count;

		while (sb.expected_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d commands: load %0d, top %0d, bottom %0d, move %0d, %s",
			sb.accepted, sb.per_cmd[CMD_LOAD], sb.per_cmd[CMD_TOP],
			sb.per_cmd[CMD_BOTTOM], sb.per_cmd[CMD_MOVE],
			$sformatf("ask %0d, query %0d, unknown %0d.", sb.per_cmd[CMD_ASK],
			sb.per_cmd[CMD_QUERY], sb.per_cmd[6] + sb.per_cmd[7]));
		$display("Checked %0d replies (%0d errors), list held %0d items, %0d mismatches.",
			sb.checked, sb.error_replies, peak, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_replies.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		int hold;
		bit held_once;
		hold = 0;
		held_once = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) sb.check_result(answer, status);
			if (!held_once && sb != null && sb.checked >= 100) begin
				held_once = 1'b1;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 30);
			end
		end
	end

endmodule
